FILE: rtl/c16eu_pkg.sv
// Shared types for the 16-bit execute unit: request and result payloads,
// operation codes, and the controller/datapath command and status groups.
// No dependencies.
package c16eu_pkg;

	// Operation codes
	typedef enum logic [3:0] {
		FN_NOP = 4'd0,  FN_MOV = 4'd1,  FN_STR = 4'd2,  FN_LOD = 4'd3,
		FN_ADD = 4'd4,  FN_SUB = 4'd5,  FN_MUL = 4'd6,  FN_MOD = 4'd7,
		FN_AND = 4'd8,  FN_OR  = 4'd9,  FN_XOR = 4'd10, FN_NOT = 4'd11,
		FN_LSL = 4'd12, FN_LSR = 4'd13, FN_CMP = 4'd14, FN_BCH = 4'd15
	} c16eu_func_t;

	localparam int unsigned DivSteps = 16;

	// Input request
	typedef struct packed {
		logic [3:0]  func;
		logic        use_immediate;
		logic [15:0] arg_a;
		logic [15:0] arg_b;
		logic [15:0] current_pc;
	} c16eu_in_t;

	// Result
	typedef struct packed {
		logic [15:0] written_value;
		logic        wrote_register;
		logic        zero_flag;
		logic        greater_flag;
		logic        less_flag;
		logic        branch_taken;
		logic [15:0] branch_target;
		logic [15:0] link_value;
	} c16eu_out_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;   // write one zero word of the clearing pass
		logic load;       // latch request, start register reads
		logic oper;       // execute operation, issue memory access
		logic mem_cap;    // capture load data
		logic div_step;   // one remainder step
		logic wb;         // register write-back and result capture
	} c16eu_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_load;
		logic is_mod;
	} c16eu_sts_t;

endpackage

FILE: rtl/cpu16_execute_unit.sv
// Each request is taken in idle, then passes through operate, a memory
// capture state for load or the remainder steps for mod, and write-back,
// which waits while an earlier result is stalled; no new request is taken
// until write-back is done. Reset: register valid bits and flags clear at once;
// the data memory is then cleared one word per cycle with in_ready low.
// Uses c16eu_pkg, c16eu_ctrl, c16eu_dp.
module cpu16_execute_unit #(
	parameter int unsigned NUM_REGS  = 8,
	parameter int unsigned MEM_WORDS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  c16eu_pkg::c16eu_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output c16eu_pkg::c16eu_out_t out_data
);
	import c16eu_pkg::*;

	c16eu_cmd_t cmd;
	c16eu_sts_t sts;

	c16eu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	c16eu_dp #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.in_data(in_data), .out_data(out_data)
	);
endmodule

FILE: rtl/c16eu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c16eu_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/c16eu_dp.sv
// Datapath of the execute unit: register file, data memory, ALU,
// remainder unit, state flags and result register. Uses c16eu_pkg, c16eu_ram.
module c16eu_dp #(
	parameter int unsigned NUM_REGS  = 8,
	parameter int unsigned MEM_WORDS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  c16eu_pkg::c16eu_cmd_t cmd,
	output c16eu_pkg::c16eu_sts_t sts,
	input  c16eu_pkg::c16eu_in_t  in_data,
	output c16eu_pkg::c16eu_out_t out_data
);
	import c16eu_pkg::*;

	localparam int unsigned RW = $clog2(NUM_REGS);
	localparam int unsigned AW = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] LastAddr = AW'(MEM_WORDS - 1);

	c16eu_in_t        instr_q;
	logic [NUM_REGS-1:0] vld_q;
	logic             dst_ok_q, src_ok_q, dst_wr_ok_q;
	logic [15:0]      rf_a_rdata, rf_b_rdata;
	logic [15:0]      dst, src;
	logic             rd_a_rng, rd_b_rng;
	logic [AW-1:0]    clr_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [15:0]      mem_wdata, mem_rdata;
	logic             src_in_mem, dst_in_mem, ld_ok_q;
	logic [15:0]      res_q;
	logic             wr_q, br_q;
	logic [15:0]      alu_res;
	logic             alu_wr;
	logic [2:0]       flags_q;   // {less, greater, zero}
	logic [15:0]      link_q;
	logic [15:0]      diff;
	logic [16:0]      rem_q, rem_sh, rem_next;
	logic [15:0]      dvd_q, dvs_q;
	logic             rf_we;
	c16eu_out_t       out_q;

	// Register index range checks on the request fields
	assign rd_a_rng = {1'b0, in_data.arg_a[3:0]} < 5'(NUM_REGS);
	assign rd_b_rng = {1'b0, in_data.arg_b[3:0]} < 5'(NUM_REGS);

	// Register file, duplicated for two read ports
	assign rf_we = cmd.wb & wr_q;

	c16eu_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(instr_q.arg_a[RW-1:0]), .wdata(res_q),
		.re(cmd.load), .raddr(in_data.arg_a[RW-1:0]), .rdata(rf_a_rdata)
	);

	c16eu_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(instr_q.arg_a[RW-1:0]), .wdata(res_q),
		.re(cmd.load), .raddr(in_data.arg_b[RW-1:0]), .rdata(rf_b_rdata)
	);

	// Request latch and register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (rf_we) begin
			vld_q[instr_q.arg_a[RW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			instr_q     <= in_data;
			dst_ok_q    <= rd_a_rng && vld_q[in_data.arg_a[RW-1:0]];
			src_ok_q    <= rd_b_rng && vld_q[in_data.arg_b[RW-1:0]];
			dst_wr_ok_q <= rd_a_rng;
		end
	end

	// Operands
	assign dst = dst_ok_q ? rf_a_rdata : 16'd0;
	assign src = instr_q.use_immediate ? instr_q.arg_b : (src_ok_q ? rf_b_rdata : 16'd0);

	// Data memory and clearing pass
	assign src_in_mem = {1'b0, src} < 17'(MEM_WORDS);
	assign dst_in_mem = {1'b0, dst} < 17'(MEM_WORDS);
	assign mem_we     = cmd.clr_step |
		(cmd.oper && instr_q.func == FN_STR && dst_in_mem);
	assign mem_waddr  = cmd.clr_step ? clr_q : dst[AW-1:0];
	assign mem_wdata  = cmd.clr_step ? 16'd0 : src;

	c16eu_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(cmd.oper), .raddr(src[AW-1:0]), .rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// ALU
	assign diff = dst - src;

	always_comb begin
		alu_res = 16'd0;
		alu_wr  = 1'b1;
		case (instr_q.func)
			FN_MOV:  alu_res = src;
			FN_ADD:  alu_res = dst + src;
			FN_SUB:  alu_res = diff;
			FN_MUL:  alu_res = 16'(dst * src);
			FN_AND:  alu_res = dst & src;
			FN_OR:   alu_res = dst | src;
			FN_XOR:  alu_res = dst ^ src;
			FN_NOT:  alu_res = ~dst;
			FN_LSL:  alu_res = (src[15:4] != 12'd0) ? 16'd0 : (dst << src[3:0]);
			FN_LSR:  alu_res = (src[15:4] != 12'd0) ? 16'd0 : (dst >> src[3:0]);
			FN_LOD:  alu_res = 16'd0;
			FN_MOD:  alu_wr  = (src != 16'd0);
			default: alu_wr  = 1'b0;
		endcase
	end

	// Flags and link register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			link_q  <= '0;
		end else if (cmd.oper) begin
			if (instr_q.func == FN_CMP) begin
				flags_q <= (diff == 16'd0) ? 3'b001 : (diff[15] ? 3'b100 : 3'b010);
			end
			if (instr_q.func == FN_BCH) begin
				link_q <= instr_q.current_pc + 16'd1;
			end
		end
	end

	// Remainder step: shift in one dividend bit, subtract when it fits
	assign rem_sh   = {rem_q[15:0], dvd_q[15]};
	assign rem_next = (rem_sh >= {1'b0, dvs_q}) ? rem_sh - {1'b0, dvs_q} : rem_sh;

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.oper) begin
			res_q   <= alu_res;
			wr_q    <= alu_wr && dst_wr_ok_q;
			br_q    <= (instr_q.func == FN_BCH);
			ld_ok_q <= src_in_mem;
			rem_q   <= '0;
			dvd_q   <= dst;
			dvs_q   <= src;
		end
		if (cmd.mem_cap) begin
			res_q <= ld_ok_q ? mem_rdata : 16'd0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[14:0], 1'b0};
			res_q <= rem_next[15:0];
		end
	end

	// Output request
	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			out_q.written_value  <= wr_q ? res_q : 16'd0;
			out_q.wrote_register <= wr_q;
			out_q.zero_flag      <= flags_q[0];
			out_q.greater_flag   <= flags_q[1];
			out_q.less_flag      <= flags_q[2];
			out_q.branch_taken   <= br_q;
			out_q.branch_target  <= br_q ? instr_q.arg_a : 16'd0;
			out_q.link_value     <= link_q;
		end
	end

	assign out_data = out_q;

	// Status
	assign sts.clr_done = (clr_q == LastAddr);
	assign sts.is_load  = (instr_q.func == FN_LOD);
	assign sts.is_mod   = (instr_q.func == FN_MOD) && (src != 16'd0);
endmodule

FILE: rtl/c16eu_ctrl.sv
// Controller of the execute unit: clearing pass, request sequencing,
// remainder step count and output handshake. Uses c16eu_pkg.
module c16eu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output c16eu_pkg::c16eu_cmd_t cmd,
	input  c16eu_pkg::c16eu_sts_t sts
);
	import c16eu_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_OPER, ST_MEM, ST_DIV, ST_WB
	} state_t;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       wb_go;

	assign wb_go = (state_q == ST_WB) && (!out_valid_q || out_ready);

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.oper     = (state_q == ST_OPER);
		cmd.mem_cap  = (state_q == ST_MEM);
		cmd.div_step = (state_q == ST_DIV);
		cmd.wb       = wb_go;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// State, step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: if (sts.clr_done) begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) begin
					state_q <= ST_OPER;
				end
				ST_OPER: begin
					cnt_q <= '0;
					if (sts.is_load) begin
						state_q <= ST_MEM;
					end else if (sts.is_mod) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_MEM: state_q <= ST_WB;
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(DivSteps - 1)) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: if (wb_go) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/c16eu_checker.sv
// Port-level checks for the execute unit, bound to the top level.
// Uses c16eu_pkg.
module c16eu_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input c16eu_pkg::c16eu_out_t out_data
);
	import c16eu_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One request in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// At most one compare flag set
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({out_data.zero_flag, out_data.greater_flag,
			out_data.less_flag}) <= 1)
		else $error("several compare flags set");

	// No write means zero value
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.wrote_register |-> out_data.written_value == 16'd0)
		else $error("value without register write");

	// No branch means zero target
	a_no_branch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.branch_taken |-> out_data.branch_target == 16'd0)
		else $error("target without branch");
endmodule

bind cpu16_execute_unit c16eu_checker u_c16eu_checker (.*);
